// ===== sv/pida_pkg.sv =====
package pida_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 3;
  localparam int OCNT_W   = 7;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 48;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_END   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_END   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADCMD = 3'd4;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] at;
  } pida_shift_t;

endpackage

// ===== sv/pida_cell.sv =====
module pida_cell (
  input  logic                           clk_i,
  input  pida_pkg::pida_shift_t          shift_i,
  input  logic [pida_pkg::IDX_W-1:0]     cell_idx_i,
  input  logic [pida_pkg::DATA_W-1:0]    ins_data_i,
  input  logic [pida_pkg::DATA_W-1:0]    left_i,
  input  logic [pida_pkg::DATA_W-1:0]    right_i,
  output logic [pida_pkg::DATA_W-1:0]    value_o,
  output logic [pida_pkg::DATA_W-1:0]    pick_o
);
  import pida_pkg::*;

  logic [DATA_W-1:0] value_q;
  logic [DATA_W-1:0] value_d;
  logic              hit;
  logic              above;

  assign hit   = (cell_idx_i == shift_i.at);
  assign above = (cell_idx_i > shift_i.at);

  always_comb begin
    value_d = value_q;
    if (shift_i.ins) begin
      if (hit) begin
        value_d = ins_data_i;
      end else if (above) begin
        value_d = left_i;
      end
    end else if (shift_i.del) begin
      if (hit || above) begin
        value_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign pick_o  = hit ? value_q : '0;

endmodule

// ===== sv/positional_insert_delete_array.sv =====
// Positional insert/delete list built as a row of shifting cells.
// Commands arrive as beats on the slave stream (s_axis_*). Each beat carries
// a command, a position and a value. Every accepted beat gives exactly one
// result beat on the master stream (m_axis_*) with a status, the removed
// value of a successful delete (zero otherwise) and the entry count after
// the command.
// An insert moves every entry at or above the position up by one cell, and a
// delete removes the entry there and moves those above it down by one, all
// cells in the same cycle.
// The result beat is registered and is valid in the cycle after acceptance.
// Throughput is one command per cycle while the result beat is taken; the
// output register lets a new command in during the cycle that the previous
// result leaves.
// When the receiver stalls, the result is held in the output register and
// s_axis_tready_o falls until it is taken.
// Reset empties the list; stored values are not cleared, as entries above
// the count are never read.
module positional_insert_delete_array (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // command [2:0], position [8:3], value [40:9], zero fill above.
  input  logic [pida_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // status [2:0], removed_value [34:3], entry_count [41:35], zero fill above.
  output logic [pida_pkg::M_TDATA_W-1:0]     m_axis_tdata_o
);
  import pida_pkg::*;

  logic [CMD_W-1:0]     cmd;
  logic [POS_W-1:0]     pos;
  logic [DATA_W-1:0]    val;
  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     cnt_ext;
  logic [CMP_W-1:0]     at;
  logic [STAT_W-1:0]    status;
  logic                 ins_ok;
  logic                 del_ok;
  logic                 s_fire;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     count_d;
  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;
  logic [DATA_W-1:0]    removed;
  logic [DATA_W-1:0]    pick_or;
  pida_shift_t          shift;

  logic [DATA_W-1:0] cell_val  [CAPACITY];
  logic [DATA_W-1:0] cell_pick [CAPACITY];

  assign cmd     = s_axis_tdata_i[2:0];
  assign pos     = s_axis_tdata_i[8:3];
  assign val     = s_axis_tdata_i[40:9];
  assign pos_ext = CMP_W'(pos);
  assign cnt_ext = CMP_W'(count_q);

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    status = ST_OK;
    at     = '0;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    unique case (cmd) inside
      CMD_INS_FRONT, CMD_INS_POS, CMD_INS_END: begin
        if (count_q >= CNT_W'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          if (cmd == CMD_INS_POS) begin
            at = pos_ext;
          end else if (cmd == CMD_INS_END) begin
            at = cnt_ext;
          end
          if (at > cnt_ext) begin
            status = ST_BADPOS;
          end else begin
            ins_ok = 1'b1;
          end
        end
      end
      CMD_DEL_FRONT, CMD_DEL_POS, CMD_DEL_END: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else begin
          if (cmd == CMD_DEL_POS) begin
            at = pos_ext;
          end else if (cmd == CMD_DEL_END) begin
            at = cnt_ext - CMP_W'(1);
          end
          if (at >= cnt_ext) begin
            status = ST_BADPOS;
          end else begin
            del_ok = 1'b1;
          end
        end
      end
      default: begin
        status = ST_BADCMD;
      end
    endcase
  end

  assign shift.ins = s_fire && ins_ok;
  assign shift.del = s_fire && del_ok;
  assign shift.at  = IDX_W'(at);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_val[g+1];
    end
    pida_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (shift),
      .cell_idx_i (IDX_W'(g)),
      .ins_data_i (val),
      .left_i     (left),
      .right_i    (right),
      .value_o    (cell_val[g]),
      .pick_o     (cell_pick[g])
    );
  end

  always_comb begin
    pick_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pick_or = pick_or | cell_pick[i];
    end
  end

  assign removed = del_ok ? pick_or : '0;

  always_comb begin
    count_d = count_q;
    if (shift.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (shift.del) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (s_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      m_data_q <= {(M_TDATA_W - STAT_W - DATA_W - OCNT_W)'(0),
                   OCNT_W'(count_d), removed, status};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> m_axis_tvalid_o)
    else $error("accepted command gave no result");

  a_ins_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && ins_ok) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the list");

  a_reject_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !ins_ok && !del_ok) |=> $stable(count_q))
    else $error("rejected command changed the count");

endmodule

// ===== dv/positional_insert_delete_array_tb.sv =====
`timescale 1ns / 100ps

module positional_insert_delete_array_tb;
  import pida_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 192;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
  } list_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] removed;
    logic [OCNT_W-1:0] count;
  } list_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;

  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];

  logic [DATA_W-1:0] list_model [CAPACITY];
  int stored_count = 0;
  int gen_count = 0;
  int sender_idle_pct = 0;
  int sink_stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  positional_insert_delete_array u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic list_result_t apply_list_command(logic [CMD_W-1:0] cmd,
                                                      logic [POS_W-1:0] pos,
                                                      logic [DATA_W-1:0] val);
    list_result_t res;
    int at;
    int i;
    res.status  = ST_OK;
    res.removed = '0;
    at = 0;
    if (cmd == CMD_INS_FRONT || cmd == CMD_INS_POS || cmd == CMD_INS_END) begin
      if (stored_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        if (cmd == CMD_INS_POS) begin
          at = int'(pos);
        end else if (cmd == CMD_INS_END) begin
          at = stored_count;
        end
        if (at > stored_count) begin
          res.status = ST_BADPOS;
        end else begin
          for (i = stored_count; i > at; i--) list_model[i] = list_model[i-1];
          list_model[at] = val;
          stored_count++;
        end
      end
    end else if (cmd == CMD_DEL_FRONT || cmd == CMD_DEL_POS || cmd == CMD_DEL_END) begin
      if (stored_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        if (cmd == CMD_DEL_POS) begin
          at = int'(pos);
        end else if (cmd == CMD_DEL_END) begin
          at = stored_count - 1;
        end
        if (at >= stored_count) begin
          res.status = ST_BADPOS;
        end else begin
          res.removed = list_model[at];
          for (i = at; i + 1 < stored_count; i++) list_model[i] = list_model[i+1];
          stored_count--;
        end
      end
    end else begin
      res.status = ST_BADCMD;
    end
    res.count = stored_count[OCNT_W-1:0];
    return res;
  endfunction

  // The generator keeps a rough count of its own so that positions mostly land inside the list.
  task automatic queue_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] val);
    list_cmd_t c;
    c.cmd = cmd;
    c.pos = pos;
    c.val = val;
    pending_cmds.push_back(c);
    if (cmd == CMD_INS_FRONT || cmd == CMD_INS_END ||
        (cmd == CMD_INS_POS && pos <= gen_count)) begin
      if (gen_count < CAPACITY) gen_count++;
    end else if (cmd == CMD_DEL_FRONT || cmd == CMD_DEL_END ||
                 (cmd == CMD_DEL_POS && pos < gen_count)) begin
      if (gen_count > 0) gen_count--;
    end
  endtask

  task automatic queue_random_command(int insert_pct);
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    int kind;
    kind = $urandom_range(2);
    if ($urandom_range(99) < 5) begin
      cmd = $urandom_range(1) ? CMD_RSVD_A : CMD_RSVD_B;
    end else if ($urandom_range(99) < insert_pct) begin
      cmd = (kind == 0) ? CMD_INS_FRONT : (kind == 1) ? CMD_INS_POS : CMD_INS_END;
    end else begin
      cmd = (kind == 0) ? CMD_DEL_FRONT : (kind == 1) ? CMD_DEL_POS : CMD_DEL_END;
    end
    if ($urandom_range(99) < 20) begin
      pos = POS_W'($urandom_range(63));
    end else if (cmd == CMD_INS_FRONT || cmd == CMD_INS_POS || cmd == CMD_INS_END) begin
      pos = POS_W'($urandom_range((gen_count > 63) ? 63 : gen_count));
    end else begin
      pos = (gen_count > 0) ? POS_W'($urandom_range(gen_count - 1)) : '0;
    end
    case ($urandom_range(19))
      0: val = 32'h7fff_ffff;
      1: val = 32'h8000_0000;
      2: val = 32'hffff_ffff;
      3: val = '0;
      default: val = $urandom;
    endcase
    queue_command(cmd, pos, val);
  endtask

  task automatic wait_for_drain();
    while (pending_cmds.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int phase;
    int made;
    int seg_len;
    int insert_pct;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_command(CMD_DEL_FRONT, 6'd0, 32'h1234_5678);
    queue_command(CMD_DEL_POS, 6'd0, '0);
    queue_command(CMD_DEL_END, 6'd63, '0);
    queue_command(CMD_INS_POS, 6'd1, 32'h0000_0001);
    queue_command(CMD_INS_FRONT, 6'd0, 32'h7fff_ffff);
    queue_command(CMD_INS_END, 6'd63, 32'h8000_0000);
    queue_command(CMD_INS_POS, 6'd1, 32'hffff_ffff);
    queue_command(CMD_INS_POS, 6'd3, 32'h0000_0000);
    queue_command(CMD_INS_POS, 6'd63, 32'h5555_5555);
    queue_command(CMD_INS_POS, 6'd5, 32'haaaa_aaaa);
    queue_command(CMD_DEL_POS, 6'd4, '0);
    queue_command(CMD_DEL_POS, 6'd63, '0);
    queue_command(CMD_DEL_POS, 6'd1, '0);
    queue_command(CMD_RSVD_A, 6'd0, 32'hdead_beef);
    queue_command(CMD_RSVD_B, 6'd63, 32'hffff_ffff);
    queue_command(CMD_DEL_FRONT, 6'd0, '0);
    queue_command(CMD_DEL_END, 6'd0, '0);
    queue_command(CMD_DEL_POS, 6'd0, '0);
    queue_command(CMD_DEL_END, 6'd0, '0);
    wait_for_drain();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 69; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 69; end
        default: begin sender_idle_pct = 14; sink_stall_pct = 14; end
      endcase
      made = 0;
      while (made < ITEMS_PER_PHASE) begin
        seg_len = $urandom_range(30, 120);
        case ($urandom_range(2))
          0: insert_pct = 90;
          1: insert_pct = 10;
          default: insert_pct = 50;
        endcase
        repeat (seg_len) begin
          if (made < ITEMS_PER_PHASE) begin
            queue_random_command(insert_pct);
            made++;
          end
        end
      end
      // The sender holds off here until every result of the phase has come back.
      wait_for_drain();
    end

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready_o) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        list_cmd_t c;
        c = pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - CMD_W - POS_W - DATA_W){1'b0}}, c.val, c.pos, c.cmd};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    list_result_t want;
    logic [STAT_W-1:0] got_status;
    logic [DATA_W-1:0] got_removed;
    logic [OCNT_W-1:0] got_count;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready_o) begin
        expected_results.push_back(apply_list_command(s_axis_tdata[CMD_W-1:0],
                                                      s_axis_tdata[CMD_W +: POS_W],
                                                      s_axis_tdata[CMD_W+POS_W +: DATA_W]));
      end
      if (m_axis_tvalid_o && m_axis_tready) begin
        got_status  = m_axis_tdata_o[STAT_W-1:0];
        got_removed = m_axis_tdata_o[STAT_W +: DATA_W];
        got_count   = m_axis_tdata_o[STAT_W+DATA_W +: OCNT_W];
        if (expected_results.size() == 0) begin
          $error("result beat with no command outstanding: status %0d", got_status);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            error_count++;
          end
          if (got_removed !== want.removed) begin
            $error("removed_value: expected %0d, got %0d",
                   $signed(want.removed), $signed(got_removed));
            error_count++;
          end
          if (got_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, got_count);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

// ===== positional_insert_delete_array.f =====
sv/pida_pkg.sv
sv/pida_cell.sv
sv/positional_insert_delete_array.sv
dv/positional_insert_delete_array_tb.sv
